// ===== src/ppu_pkg.sv =====
// Shared types and constants of the porosity and permeability update block.
package ppu_pkg;

  localparam int NUM_SPECIES_DEF = 2;
  localparam int MAX_SPECIES     = 2;
  localparam int ADDR_W          = 5;
  localparam int VF_W            = 38;
  localparam int NUM_W           = 112;
  localparam int DEN_W           = 80;
  localparam int POR_QBITS       = 16;
  localparam int PERM_QBITS      = 32;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [15:0] POR_MIN  = 16'd66;
  localparam logic [15:0] POR_MAX  = 16'hFFFF;
  localparam logic [31:0] PERM_MAX = 32'hFFFF_FFFF;

  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_NI     = 3'd1;
  localparam logic [2:0] REG_KI     = 3'd2;
  localparam logic [2:0] REG_DIFF   = 3'd3;
  localparam logic [2:0] REG_IVF    = 3'd4;
  localparam logic [2:0] REG_COEF0  = 3'd5;
  localparam logic [2:0] REG_COEF1  = 3'd6;

  typedef struct packed {
    logic                              en;
    logic [15:0]                       ni;
    logic [31:0]                       ki;
    logic [31:0]                       cd;
    logic [31:0]                       ivf;
    logic [MAX_SPECIES-1:0][31:0]      coef;
  } ppu_cfg_t;

  typedef struct packed {
    logic            byp;
    logic [VF_W-1:0] vf;
  } ppu_item_t;

endpackage

// ===== src/ppu_cfg.sv =====
// Configuration register file behind the APB-style port.
module ppu_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ppu_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output ppu_pkg::ppu_cfg_t          cfg
);
  import ppu_pkg::*;

  ppu_cfg_t   cfg_r;
  logic       wr;
  logic [2:0] idx;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[ADDR_W-1:2];
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.en      <= 1'b0;
      cfg_r.ni      <= 16'd19661;
      cfg_r.ki      <= 32'd1000000;
      cfg_r.cd      <= 32'd10000;
      cfg_r.ivf     <= 32'd65536;
      cfg_r.coef[0] <= 32'd0;
      cfg_r.coef[1] <= 32'd0;
    end else if (wr) begin
      unique case (idx)
        REG_ENABLE: cfg_r.en      <= pwdata[0];
        REG_NI:     cfg_r.ni      <= pwdata[15:0];
        REG_KI:     cfg_r.ki      <= pwdata;
        REG_DIFF:   cfg_r.cd      <= pwdata;
        REG_IVF:    cfg_r.ivf     <= pwdata;
        REG_COEF0:  cfg_r.coef[0] <= pwdata;
        REG_COEF1:  cfg_r.coef[1] <= pwdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ENABLE: prdata = {31'd0, cfg_r.en};
      REG_NI:     prdata = {16'd0, cfg_r.ni};
      REG_KI:     prdata = cfg_r.ki;
      REG_DIFF:   prdata = cfg_r.cd;
      REG_IVF:    prdata = cfg_r.ivf;
      REG_COEF0:  prdata = cfg_r.coef[0];
      REG_COEF1:  prdata = cfg_r.coef[1];
      default:    prdata = 32'd0;
    endcase
  end

endmodule

// ===== src/ppu_front.sv =====
// Front end: accept points, form the volume factor and mark pass-through items.
module ppu_front #(
  parameter int NUM_SPECIES = ppu_pkg::NUM_SPECIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [63:0]        in_data,
  input  ppu_pkg::ppu_cfg_t  cfg,
  input  logic               q_full,
  output logic               push,
  output ppu_pkg::ppu_item_t push_item
);
  import ppu_pkg::*;

  logic [63:0]     prod_r [NUM_SPECIES];
  logic            f1_v_r;
  logic            f1_byp_r;
  logic            f2_v_r;
  ppu_item_t       item_r;
  logic [VF_W-1:0] vf_nxt;
  logic            adv;

  assign adv       = !(f2_v_r && q_full);
  assign in_ready  = adv;
  assign push      = f2_v_r && !q_full;
  assign push_item = item_r;

  always_comb begin
    vf_nxt = VF_W'(65536);
    for (int i = 0; i < NUM_SPECIES; i++) begin
      vf_nxt = vf_nxt + VF_W'(prod_r[i][63:28]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else if (adv) begin
      f1_v_r <= in_valid;
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NUM_SPECIES; i++) begin
        prod_r[i] <= 64'(cfg.coef[i]) * 64'(in_data[32*i +: 32]);
      end
      f1_byp_r    <= !cfg.en;
      item_r.byp  <= f1_byp_r;
      item_r.vf   <= vf_nxt;
    end
  end

endmodule

// ===== src/ppu_queue.sv =====
// Short queue between the front end and the arithmetic back end.
module ppu_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ppu_pkg::ppu_item_t push_item,
  input  logic               pop,
  output logic               full,
  output logic               empty,
  output ppu_pkg::ppu_item_t pop_item
);
  import ppu_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  ppu_item_t        mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  assign full     = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

// ===== src/ppu_back.sv =====
// Back end: porosity division, Carman-Kozeny products, permeability division, result register.
module ppu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ppu_pkg::ppu_cfg_t  cfg,
  input  logic               q_empty,
  input  ppu_pkg::ppu_item_t q_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_por,
  output logic [31:0]        out_perm,
  output logic [31:0]        out_diff,
  output logic               out_sat
);
  import ppu_pkg::*;

  logic adv;

  // entry stage
  logic            s0_v_r;
  logic            s0_byp_r;
  logic [VF_W-1:0] s0_vf_r;
  logic [47:0]     s0_num_r;

  // porosity divider, index 0 is the overflow check
  logic                 pd_v_r   [POR_QBITS+1];
  logic                 pd_byp_r [POR_QBITS+1];
  logic                 pd_ovf_r [POR_QBITS+1];
  logic [VF_W-1:0]      pd_vf_r  [POR_QBITS+1];
  logic [VF_W-1:0]      pd_rem_r [POR_QBITS+1];
  logic [POR_QBITS-1:0] pd_nl_r  [POR_QBITS+1];
  logic [POR_QBITS-1:0] pd_q_r   [POR_QBITS+1];

  // clamp and product stages
  logic        c_v_r, c_byp_r, c_sat_r;
  logic [15:0] c_por_r, c_dn_r;
  logic [15:0] di;
  logic [15:0] por_clamp;

  logic        m1_v_r, m1_byp_r, m1_sat_r;
  logic [15:0] m1_por_r;
  logic [31:0] m1_por2_r, m1_dn2_r, m1_di2_r, m1_ni2_r, m1_diff_r;
  logic [47:0] m1_diff_full;

  logic        m2_v_r, m2_byp_r, m2_sat_r;
  logic [15:0] m2_por_r;
  logic [31:0] m2_dn2_r, m2_diff_r;
  logic [47:0] m2_por3_r, m2_ni3_r;
  logic [63:0] m2_a_r;

  logic        m3_v_r, m3_byp_r, m3_sat_r;
  logic [15:0] m3_por_r;
  logic [31:0] m3_diff_r;
  logic [55:0] m3_pp0_r, m3_pp1_r, m3_pp2_r, m3_pp3_r, m3_dp0_r, m3_dp1_r;

  logic             m4_v_r, m4_byp_r, m4_sat_r;
  logic [15:0]      m4_por_r;
  logic [31:0]      m4_diff_r;
  logic [NUM_W-1:0] m4_num_r;
  logic [DEN_W-1:0] m4_den_r;

  // permeability divider, index 0 is the overflow check
  logic                  kd_v_r   [PERM_QBITS+1];
  logic                  kd_byp_r [PERM_QBITS+1];
  logic                  kd_sat_r [PERM_QBITS+1];
  logic                  kd_ovk_r [PERM_QBITS+1];
  logic [15:0]           kd_por_r [PERM_QBITS+1];
  logic [31:0]           kd_diff_r[PERM_QBITS+1];
  logic [DEN_W-1:0]      kd_den_r [PERM_QBITS+1];
  logic [DEN_W-1:0]      kd_rem_r [PERM_QBITS+1];
  logic [PERM_QBITS-1:0] kd_nl_r  [PERM_QBITS+1];
  logic [PERM_QBITS-1:0] kd_q_r   [PERM_QBITS+1];

  logic        o_v_r, o_byp_r, o_sat_r;
  logic [15:0] o_por_r;
  logic [31:0] o_perm_r, o_diff_r;

  assign adv       = !o_v_r || out_ready;
  assign pop       = adv && !q_empty;
  assign out_valid = o_v_r;
  assign out_por   = o_por_r;
  assign out_perm  = o_perm_r;
  assign out_diff  = o_diff_r;
  assign out_sat   = o_sat_r;

  assign di           = 16'(17'h10000 - {1'b0, cfg.ni});
  assign m1_diff_full = 48'(cfg.cd) * 48'(c_por_r);

  always_comb begin
    if (pd_ovf_r[POR_QBITS]) begin
      por_clamp = POR_MAX;
    end else if (pd_q_r[POR_QBITS] < POR_MIN) begin
      por_clamp = POR_MIN;
    end else begin
      por_clamp = pd_q_r[POR_QBITS];
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r      <= 1'b0;
      pd_v_r[0]   <= 1'b0;
      c_v_r       <= 1'b0;
      m1_v_r      <= 1'b0;
      m2_v_r      <= 1'b0;
      m3_v_r      <= 1'b0;
      m4_v_r      <= 1'b0;
      kd_v_r[0]   <= 1'b0;
      o_v_r       <= 1'b0;
    end else if (adv) begin
      s0_v_r      <= !q_empty;
      pd_v_r[0]   <= s0_v_r;
      c_v_r       <= pd_v_r[POR_QBITS];
      m1_v_r      <= c_v_r;
      m2_v_r      <= m1_v_r;
      m3_v_r      <= m2_v_r;
      m4_v_r      <= m3_v_r;
      kd_v_r[0]   <= m4_v_r;
      o_v_r       <= kd_v_r[PERM_QBITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_byp_r <= q_item.byp;
      s0_vf_r  <= q_item.vf;
      s0_num_r <= 48'(cfg.ivf) * 48'(cfg.ni);

      pd_byp_r[0] <= s0_byp_r;
      pd_vf_r[0]  <= s0_vf_r;
      pd_ovf_r[0] <= {6'd0, s0_num_r} >= {s0_vf_r, 16'd0};
      pd_rem_r[0] <= VF_W'(s0_num_r[47:16]);
      pd_nl_r[0]  <= s0_num_r[15:0];
      pd_q_r[0]   <= '0;

      c_byp_r <= pd_byp_r[POR_QBITS];
      c_sat_r <= pd_ovf_r[POR_QBITS];
      c_por_r <= por_clamp;
      c_dn_r  <= 16'(17'h10000 - {1'b0, por_clamp});

      m1_byp_r  <= c_byp_r;
      m1_sat_r  <= c_sat_r;
      m1_por_r  <= c_por_r;
      m1_por2_r <= 32'(c_por_r) * 32'(c_por_r);
      m1_dn2_r  <= 32'(c_dn_r) * 32'(c_dn_r);
      m1_di2_r  <= 32'(di) * 32'(di);
      m1_ni2_r  <= 32'(cfg.ni) * 32'(cfg.ni);
      m1_diff_r <= m1_diff_full[47:16];

      m2_byp_r  <= m1_byp_r;
      m2_sat_r  <= m1_sat_r;
      m2_por_r  <= m1_por_r;
      m2_dn2_r  <= m1_dn2_r;
      m2_diff_r <= m1_diff_r;
      m2_por3_r <= 48'(m1_por2_r) * 48'(m1_por_r);
      m2_ni3_r  <= 48'(m1_ni2_r) * 48'(cfg.ni);
      m2_a_r    <= 64'(cfg.ki) * 64'(m1_di2_r);

      m3_byp_r  <= m2_byp_r;
      m3_sat_r  <= m2_sat_r;
      m3_por_r  <= m2_por_r;
      m3_diff_r <= m2_diff_r;
      m3_pp0_r  <= 56'(m2_a_r[31:0])  * 56'(m2_por3_r[23:0]);
      m3_pp1_r  <= 56'(m2_a_r[31:0])  * 56'(m2_por3_r[47:24]);
      m3_pp2_r  <= 56'(m2_a_r[63:32]) * 56'(m2_por3_r[23:0]);
      m3_pp3_r  <= 56'(m2_a_r[63:32]) * 56'(m2_por3_r[47:24]);
      m3_dp0_r  <= 56'(m2_ni3_r[23:0])  * 56'(m2_dn2_r);
      m3_dp1_r  <= 56'(m2_ni3_r[47:24]) * 56'(m2_dn2_r);

      m4_byp_r  <= m3_byp_r;
      m4_sat_r  <= m3_sat_r;
      m4_por_r  <= m3_por_r;
      m4_diff_r <= m3_diff_r;
      m4_num_r  <= NUM_W'(m3_pp0_r) + (NUM_W'(m3_pp1_r) << 24)
                 + (NUM_W'(m3_pp2_r) << 32) + (NUM_W'(m3_pp3_r) << 56);
      m4_den_r  <= DEN_W'(m3_dp0_r) + (DEN_W'(m3_dp1_r) << 24);

      kd_byp_r[0]  <= m4_byp_r;
      kd_sat_r[0]  <= m4_sat_r;
      kd_por_r[0]  <= m4_por_r;
      kd_diff_r[0] <= m4_diff_r;
      kd_den_r[0]  <= m4_den_r;
      kd_ovk_r[0]  <= m4_num_r >= {m4_den_r, 32'd0};
      kd_rem_r[0]  <= m4_num_r[NUM_W-1:32];
      kd_nl_r[0]   <= m4_num_r[31:0];
      kd_q_r[0]    <= '0;

      o_byp_r <= kd_byp_r[PERM_QBITS];
      if (kd_byp_r[PERM_QBITS]) begin
        o_por_r  <= cfg.ni;
        o_perm_r <= cfg.ki;
        o_diff_r <= cfg.cd;
        o_sat_r  <= 1'b0;
      end else begin
        o_por_r  <= kd_por_r[PERM_QBITS];
        o_diff_r <= kd_diff_r[PERM_QBITS];
        if ((cfg.ni == 16'd0) || kd_ovk_r[PERM_QBITS]) begin
          o_perm_r <= PERM_MAX;
          o_sat_r  <= 1'b1;
        end else begin
          o_perm_r <= kd_q_r[PERM_QBITS];
          o_sat_r  <= kd_sat_r[PERM_QBITS];
        end
      end
    end
  end

  for (genvar k = 1; k <= POR_QBITS; k++) begin : g_pd
    logic [VF_W:0] t;
    logic          ge;
    assign t  = {pd_rem_r[k-1], pd_nl_r[k-1][POR_QBITS-k]};
    assign ge = t >= {1'b0, pd_vf_r[k-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pd_v_r[k] <= 1'b0;
      end else if (adv) begin
        pd_v_r[k] <= pd_v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pd_rem_r[k] <= ge ? VF_W'(t - {1'b0, pd_vf_r[k-1]}) : t[VF_W-1:0];
        pd_q_r[k]   <= {pd_q_r[k-1][POR_QBITS-2:0], ge};
        pd_nl_r[k]  <= pd_nl_r[k-1];
        pd_vf_r[k]  <= pd_vf_r[k-1];
        pd_byp_r[k] <= pd_byp_r[k-1];
        pd_ovf_r[k] <= pd_ovf_r[k-1];
      end
    end
  end

  for (genvar j = 1; j <= PERM_QBITS; j++) begin : g_kd
    logic [DEN_W:0] t;
    logic           ge;
    assign t  = {kd_rem_r[j-1], kd_nl_r[j-1][PERM_QBITS-j]};
    assign ge = t >= {1'b0, kd_den_r[j-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        kd_v_r[j] <= 1'b0;
      end else if (adv) begin
        kd_v_r[j] <= kd_v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        kd_rem_r[j]  <= ge ? DEN_W'(t - {1'b0, kd_den_r[j-1]}) : t[DEN_W-1:0];
        kd_q_r[j]    <= {kd_q_r[j-1][PERM_QBITS-2:0], ge};
        kd_nl_r[j]   <= kd_nl_r[j-1];
        kd_den_r[j]  <= kd_den_r[j-1];
        kd_byp_r[j]  <= kd_byp_r[j-1];
        kd_sat_r[j]  <= kd_sat_r[j-1];
        kd_ovk_r[j]  <= kd_ovk_r[j-1];
        kd_por_r[j]  <= kd_por_r[j-1];
        kd_diff_r[j] <= kd_diff_r[j-1];
      end
    end
  end

  a_por_floor: assert property (@(posedge clk) disable iff (!rst_n)
    o_v_r && !o_byp_r |-> o_por_r >= POR_MIN)
    else $error("updated porosity below lower clamp");

  a_byp_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
    o_v_r && o_byp_r |-> !o_sat_r)
    else $error("pass-through result flagged as saturated");

  a_tail_load: assert property (@(posedge clk) disable iff (!rst_n)
    adv && kd_v_r[PERM_QBITS] |=> o_v_r)
    else $error("finished item lost before result register");

endmodule

// ===== src/porosity_permeability_update.sv =====
// Top level of the porosity and permeability update block.
// Takes one mesh point per cycle unless the output stalls and returns one result per point, in
// order. The path runs through two front stages, the queue, then a back pipeline whose length
// is set by the two restoring dividers (16 stages for porosity, 32 for permeability) plus the
// product stages. Sustained rate is one item per clock while out_tready stays high; a stalled
// output holds the whole back pipeline and the queue absorbs the front end. Write registers
// only while no item is in flight.
module porosity_permeability_update #(
  parameter int NUM_SPECIES = ppu_pkg::NUM_SPECIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [63:0]                in_tdata,   // concentration_0, concentration_1
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [79:0]                out_tdata,  // porosity, permeability, diffusivity
  output logic                       out_tuser,  // saturated
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [ppu_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import ppu_pkg::*;

  ppu_cfg_t    cfg;
  ppu_item_t   push_item;
  ppu_item_t   pop_item;
  logic        push, pop, q_full, q_empty;
  logic [15:0] por;
  logic [31:0] perm, diff;

  assign cfg_pready = 1'b1;
  assign out_tdata  = {diff, perm, por};

  ppu_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  ppu_front #(.NUM_SPECIES(NUM_SPECIES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_tdata),
    .cfg       (cfg),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  ppu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .pop_item  (pop_item)
  );

  ppu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_item    (pop_item),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_por   (por),
    .out_perm  (perm),
    .out_diff  (diff),
    .out_sat   (out_tuser)
  );

endmodule

// ===== tb/porosity_permeability_update_test.sv =====
// Testbench for the porosity and permeability update block: random and directed points, scoreboard.
`timescale 1ns / 100ps

module porosity_permeability_update_test;
  import ppu_pkg::*;

  typedef struct {
    logic [15:0] por;
    logic [31:0] perm;
    logic [31:0] diff;
    logic        sat;
  } point_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic        out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  porosity_permeability_update uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic        en_m;
  logic [15:0] ni_m;
  logic [31:0] ki_m, cd_m, ivf_m;
  logic [31:0] coef_m [2];

  logic [63:0]   point_q [$];
  point_result_t expected_q [$];
  int errors = 0;
  int wd = 0;
  int in_gap = 0;
  int out_gap = 0;

  function automatic point_result_t predict_point(logic [63:0] conc);
    point_result_t r;
    logic [63:0]  vf, raw;
    logic [15:0]  por;
    logic [255:0] num, den, q;
    logic [16:0]  di, dn;
    r.sat = 1'b0;
    if (!en_m) begin
      r.por = ni_m; r.perm = ki_m; r.diff = cd_m;
      return r;
    end
    vf = 64'd65536 + ((64'(coef_m[0]) * 64'(conc[31:0])) >> 28)
                   + ((64'(coef_m[1]) * 64'(conc[63:32])) >> 28);
    raw = (64'(ivf_m) * 64'(ni_m)) / vf;
    if (raw < 66) por = POR_MIN;
    else if (raw > 65535) begin por = POR_MAX; r.sat = 1'b1; end
    else por = raw[15:0];
    if (ni_m == 0) begin
      r.perm = PERM_MAX; r.sat = 1'b1;
    end else begin
      di = 17'd65536 - ni_m;
      dn = 17'd65536 - por;
      num = 256'(di) * di * por * por * por * ki_m;
      den = 256'(ni_m) * ni_m * ni_m * dn * dn;
      q = num / den;
      if (q > 256'hFFFF_FFFF) begin r.perm = PERM_MAX; r.sat = 1'b1; end
      else r.perm = q[31:0];
    end
    r.por = por;
    r.diff = 32'((64'(cd_m) * por) >> 16);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid && in_tready) begin
        expected_q.push_back(predict_point(in_tdata));
        in_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
      end
      if (in_gap > 0 || point_q.size() == 0) begin
        in_tvalid <= 1'b0;
        if (in_gap > 0) in_gap--;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata <= point_q.pop_front();
      end
    end
  end

  always @(posedge clk) begin
    point_result_t e;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) wd = 0;
      else wd++;
      if (wd > 5000) begin
        $display("[porosity_permeability_update] ERROR");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", out_tdata);
        end else begin
          e = expected_q.pop_front();
          if (out_tdata[15:0] !== e.por || out_tdata[47:16] !== e.perm ||
              out_tdata[79:48] !== e.diff || out_tuser !== e.sat) begin
            errors++;
            if (errors <= 10)
              $display("mismatch exp %h %h %h %b got %h %h %h %b", e.por, e.perm, e.diff,
                       e.sat, out_tdata[15:0], out_tdata[47:16], out_tdata[79:48],
                       out_tuser);
          end
        end
        out_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
      end
      if (out_gap > 0) begin
        out_tready <= 1'b0;
        out_gap--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= ADDR_W'({idx, 2'b00}); cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      REG_ENABLE: en_m = val[0];
      REG_NI:     ni_m = val[15:0];
      REG_KI:     ki_m = val;
      REG_DIFF:   cd_m = val;
      REG_IVF:    ivf_m = val;
      REG_COEF0:  coef_m[0] = val;
      REG_COEF1:  coef_m[1] = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (point_q.size() != 0 || in_tvalid || expected_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 65535);
      3: return $urandom_range(0, 1 << 20);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_setting(bit en);
    write_reg(REG_ENABLE, {31'd0, en});
    case ($urandom_range(0, 5))
      0: write_reg(REG_NI, 32'd0);
      1: write_reg(REG_NI, 32'd65535);
      2: write_reg(REG_NI, 32'd1);
      default: write_reg(REG_NI, $urandom_range(1000, 60000));
    endcase
    write_reg(REG_KI, $urandom_range(0, 3) == 0 ? pick32() : $urandom_range(1, 1 << 24));
    write_reg(REG_DIFF, pick32());
    case ($urandom_range(0, 3))
      0: write_reg(REG_IVF, pick32());
      default: write_reg(REG_IVF, $urandom_range(65536, 1 << 18));
    endcase
    write_reg(REG_COEF0, $urandom_range(0, 1) ? pick32() : $urandom_range(0, 1 << 24));
    write_reg(REG_COEF1, $urandom_range(0, 1) ? pick32() : $urandom_range(0, 1 << 24));
  endtask

  initial begin
    en_m = 1'b0; ni_m = 16'd19661; ki_m = 32'd1000000; cd_m = 32'd10000;
    ivf_m = 32'd65536; coef_m[0] = '0; coef_m[1] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    point_q.push_back(64'h0);
    point_q.push_back('1);
    drain();
    write_reg(REG_ENABLE, 32'd1);
    write_reg(REG_COEF0, 32'h1000_0000);
    write_reg(REG_COEF1, 32'hFFFF_FFFF);
    point_q.push_back(64'h0);
    point_q.push_back({32'h0, 32'hFFFF_FFFF});
    point_q.push_back({32'hFFFF_FFFF, 32'h0});
    point_q.push_back('1);
    point_q.push_back({32'h0, 32'h0001_0000});
    drain();
    write_reg(REG_IVF, 32'hFFFF_FFFF);
    write_reg(REG_NI, 32'd65535);
    write_reg(REG_KI, 32'hFFFF_FFFF);
    write_reg(REG_DIFF, 32'hFFFF_FFFF);
    point_q.push_back(64'h0);
    point_q.push_back('1);
    drain();
    write_reg(REG_NI, 32'd0);
    point_q.push_back(64'h0);
    point_q.push_back({32'h0, 32'h0010_0000});
    drain();
    write_reg(REG_NI, 32'd1);
    write_reg(REG_IVF, 32'd0);
    point_q.push_back(64'h0);
    point_q.push_back(64'h5555_5555_AAAA_AAAA);
    drain();
    for (int ph = 0; ph < 19; ph++) begin
      random_setting(ph % 6 != 5);
      for (int k = 0; k < 100; k++) point_q.push_back({pick32(), pick32()});
      drain();
    end
    if (errors == 0) $display("[porosity_permeability_update] OK");
    else $display("[porosity_permeability_update] ERROR");
    $finish;
  end

endmodule
